FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk while reset is released.
`define SLCFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define SLCFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/slcfr_pkg.sv
// Types, constants and codes of the frame receiver.
`default_nettype none

package slcfr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

    localparam logic [7:0]  START_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  START_SECOND_RST = 8'h55;
    localparam logic [15:0] LENGTH_LIMIT_RST = 16'd1024;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT0   = 3'd0,
        PH_HUNT1   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TRAIL0  = 3'd4,
        PH_TRAIL1  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0]  start_first;
        logic [7:0]  start_second;
        logic [15:0] length_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_type;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [15:0] crc_received;
        logic [15:0] crc_computed;
        logic        frame_end;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
        logic [31:0] bytes_seen;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/slcfr_parser.sv
// Frame parser: start byte hunt, header capture, byte-wide CRC and verdict.
`default_nettype none

module slcfr_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic [7:0]         i_rx_byte,
    input  wire slcfr_pkg::t_cfg    i_cfg,
    output slcfr_pkg::t_result      o_res,
    output logic                    o_res_valid
);
    import slcfr_pkg::*;

    // One byte through the CCITT polynomial, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr_pos, n_hdr_pos;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_trail_low, n_trail_low;
    logic [31:0] r_good, n_good;
    logic [31:0] r_bad, n_bad;
    logic [31:0] r_bytes, n_bytes;

    logic [15:0] crc_next;
    logic [15:0] rx_crc;

    assign crc_next = crc_feed(r_crc, i_rx_byte);
    assign rx_crc   = {i_rx_byte, r_trail_low};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_type      = r_type;
        n_id        = r_id;
        n_len       = r_len;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_trail_low = r_trail_low;
        n_good      = r_good;
        n_bad       = r_bad;
        n_bytes     = r_bytes + 32'd1;
        o_res_valid = 1'b0;

        case (r_phase)
            PH_HUNT1: begin
                if (i_rx_byte == i_cfg.start_second) begin
                    n_phase   = PH_HEADER;
                    n_hdr_pos = 2'd0;
                    n_crc     = CRC_INIT;
                end else begin
                    n_phase = PH_HUNT0;
                end
            end
            PH_HEADER: begin
                n_crc = crc_next;
                case (r_hdr_pos)
                    2'd0:    n_type = i_rx_byte;
                    2'd1:    n_id   = i_rx_byte;
                    2'd2:    n_len  = {8'h00, i_rx_byte};
                    default: n_len  = {i_rx_byte, r_len[7:0]};
                endcase
                if (r_hdr_pos == 2'd3) begin
                    n_hdr_pos = 2'd0;
                    n_pos     = 16'd0;
                    if (n_len > i_cfg.length_limit) begin
                        n_phase = PH_HUNT0;
                    end else if (n_len == 16'd0) begin
                        n_phase = PH_TRAIL0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_hdr_pos = r_hdr_pos + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                n_crc       = crc_next;
                n_pos       = r_pos + 16'd1;
                o_res_valid = 1'b1;
                if (n_pos >= r_len) begin
                    n_phase = PH_TRAIL0;
                end
            end
            PH_TRAIL0: begin
                n_trail_low = i_rx_byte;
                n_phase     = PH_TRAIL1;
            end
            PH_TRAIL1: begin
                if (rx_crc == r_crc) begin
                    n_good = r_good + 32'd1;
                end else begin
                    n_bad = r_bad + 32'd1;
                end
                o_res_valid = 1'b1;
                n_phase     = PH_HUNT0;
            end
            default: begin
                n_phase = (i_rx_byte == i_cfg.start_first) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    // Result fields; only meaningful when o_res_valid is set.
    always_comb begin
        o_res.frame_type     = r_type;
        o_res.msg_id         = r_id;
        o_res.payload_length = r_len;
        o_res.crc_computed   = n_crc;
        o_res.good_frames    = n_good;
        o_res.bad_frames     = n_bad;
        o_res.bytes_seen     = n_bytes;
        if (r_phase == PH_TRAIL1) begin
            o_res.kind         = (rx_crc == r_crc) ? KIND_GOOD : KIND_BAD;
            o_res.data_byte    = 8'h00;
            o_res.byte_index   = 16'd0;
            o_res.crc_received = rx_crc;
            o_res.frame_end    = 1'b1;
        end else begin
            o_res.kind         = KIND_PAYLOAD;
            o_res.data_byte    = i_rx_byte;
            o_res.byte_index   = r_pos;
            o_res.crc_received = 16'd0;
            o_res.frame_end    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT0;
            r_hdr_pos   <= 2'd0;
            r_type      <= 8'h00;
            r_id        <= 8'h00;
            r_len       <= 16'd0;
            r_pos       <= 16'd0;
            r_crc       <= CRC_INIT;
            r_trail_low <= 8'h00;
            r_good      <= 32'd0;
            r_bad       <= 32'd0;
            r_bytes     <= 32'd0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_hdr_pos   <= n_hdr_pos;
            r_type      <= n_type;
            r_id        <= n_id;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_trail_low <= n_trail_low;
            r_good      <= n_good;
            r_bad       <= n_bad;
            r_bytes     <= n_bytes;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sof_length_crc_frame_receiver_unit.sv
// Top level of the start-of-frame / length / CRC16 frame receiver.
//
// The input channel (i_in_valid, o_in_stall, i_rx_byte) takes one received
// byte per transaction. The receiver hunts for the two start bytes, reads a
// four-byte header (type, id, little-endian length), streams each payload
// byte out as a result, and closes the frame with a good or bad verdict
// after the second little-endian CRC16 trailer byte. Frames whose length
// exceeds length_limit are dropped without any result.
// A byte is fully processed in the cycle it is taken; its result, if any, is
// buffered for the output channel (o_out_valid, i_out_stall). One byte can be
// taken every cycle while o_in_stall is low; the byte-wide CRC update sets that rate.
// A two-entry output buffer (result register plus skid register) keeps input
// open while one result waits; o_in_stall rises only when both are full.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is written by the user only while
// idle; the block does not enforce it. Synchronous reset clears the parser, the
// counters and the output buffer and restores the default start bytes and length limit.
`default_nettype none

module sof_length_crc_frame_receiver_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [slcfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [slcfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_rx_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_kind,
    output logic [7:0]                             o_data_byte,
    output logic [15:0]                            o_byte_index,
    output logic [7:0]                             o_frame_type,
    output logic [7:0]                             o_msg_id,
    output logic [15:0]                            o_payload_length,
    output logic [15:0]                            o_crc_received,
    output logic [15:0]                            o_crc_computed,
    output logic                                   o_frame_end,
    output logic [31:0]                            o_good_frames,
    output logic [31:0]                            o_bad_frames,
    output logic [31:0]                            o_bytes_seen
);
    import slcfr_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    logic    res_valid;
    logic    take;
    logic    push;
    logic    pop;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= START_FIRST_RST;
            r_cfg.start_second <= START_SECOND_RST;
            r_cfg.length_limit <= LENGTH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_FIRST:  r_cfg.start_first  <= i_cfg_data[7:0];
                REG_START_SECOND: r_cfg.start_second <= i_cfg_data[7:0];
                REG_LENGTH_LIMIT: r_cfg.length_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_skid_valid;
    assign take       = i_in_valid && !r_skid_valid;
    assign push       = take && res_valid;
    assign pop        = r_out_valid && !i_out_stall;

    slcfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    // The skid register only fills when a result arrives while the result
    // register is held; input is stalled until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data_byte      = r_out.data_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_frame_type     = r_out.frame_type;
    assign o_msg_id         = r_out.msg_id;
    assign o_payload_length = r_out.payload_length;
    assign o_crc_received   = r_out.crc_received;
    assign o_crc_computed   = r_out.crc_computed;
    assign o_frame_end      = r_out.frame_end;
    assign o_good_frames    = r_out.good_frames;
    assign o_bad_frames     = r_out.bad_frames;
    assign o_bytes_seen     = r_out.bytes_seen;

endmodule

`default_nettype wire

FILE: rtl/slcfr_checker.sv
// Port-level assertions for the frame receiver and their bind statement.
`default_nettype none
`include "assert_macros.svh"

module slcfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_data_byte,
    input wire logic [15:0] o_crc_received,
    input wire logic [15:0] o_crc_computed,
    input wire logic        o_frame_end,
    input wire logic [31:0] o_bytes_seen
);
    import slcfr_pkg::*;

    logic        end_ok;
    logic        verdict_ok;
    logic        stalled;
    logic        buf_busy;
    logic [41:0] held_view;

    // A verdict closes the frame; a payload byte never does.
    assign end_ok     = (o_kind inside {KIND_PAYLOAD, KIND_GOOD, KIND_BAD})
                        && (o_frame_end == (o_kind != KIND_PAYLOAD));
    // The verdict must agree with the two CRC values it reports.
    assign verdict_ok = ((o_kind == KIND_GOOD) == (o_crc_received == o_crc_computed));
    assign stalled    = o_out_valid && i_out_stall;
    assign buf_busy   = o_out_valid || o_in_stall;
    assign held_view  = {o_kind, o_data_byte, o_bytes_seen};

    `SLCFR_ASSERT(a_frame_end_kind, o_out_valid |-> end_ok, "frame_end disagrees with kind")

    `SLCFR_ASSERT(a_verdict_crc, o_out_valid && o_frame_end |-> verdict_ok, "verdict vs CRC")

    // A held result transaction keeps its payload.
    `SLCFR_ASSERT(a_out_hold, stalled |=> o_out_valid && $stable(held_view), "result changed")

    // Reset empties the output buffer and opens the input.
    `SLCFR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !buf_busy, "buffer busy after reset")

endmodule

bind sof_length_crc_frame_receiver_unit slcfr_checker u_slcfr_checker (.*);

`default_nettype wire
